/* design/hash_ring_successor_walk_assert.svh */
// Assertion macros used by the ring lookup checker.
`ifndef HASH_RING_SUCCESSOR_WALK_ASSERT_SVH
`define HASH_RING_SUCCESSOR_WALK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRSW_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("hrsw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRSW_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("hrsw assertion failed");

`endif

/* design/hrsw_pkg.sv */
// Shared types and constants of the hash ring successor walk.
`timescale 1ns / 1ps
package hrsw_pkg;

	localparam int VNODES_DEF = 1024;
	localparam int NODES_DEF  = 16;

	localparam int ENTRY_INDEX_W = 10;
	localparam int ID_W          = 64;
	localparam int OWNER_W       = 4;
	localparam int VNODE_IDX_W   = 10;
	localparam int LIMIT_W       = 5;
	localparam int OWNER_SLOTS   = 16;

	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_VNODE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_WRD,
		S_WEV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic srch_rd;
		logic srch_upd;
		logic walk_init;
		logic walk_rd;
		logic walk_step;
		logic walk_take;
		logic fin_push;
	} cmd_t;

	typedef struct packed {
		logic srch_more;
		logic walk_more;
		logic is_new;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage

/* design/hrsw_ctrl.sv */
// Sequencer of the ring lookup: request intake, binary search and clockwise walk.
`timescale 1ns / 1ps
module hrsw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_func,
	output logic          in_ready,
	input  hrsw_pkg::sts_t sts,
	output hrsw_pkg::cmd_t cmd
);
	import hrsw_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_nxt = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (sts.srch_more) begin
					cmd.srch_rd = 1'b1;
					state_nxt   = S_CMP;
				end else begin
					cmd.walk_init = 1'b1;
					state_nxt     = S_WRD;
				end
			end
			S_CMP: begin
				cmd.srch_upd = 1'b1;
				state_nxt    = S_SRCH;
			end
			S_WRD: begin
				if (sts.walk_more) begin
					cmd.walk_rd = 1'b1;
					state_nxt   = S_WEV;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_WEV: begin
				if (!sts.is_new) begin
					cmd.walk_step = 1'b1;
					state_nxt     = S_WRD;
				end else if (!sts.pend_valid || sts.out_free) begin
					cmd.walk_take = 1'b1;
					state_nxt     = S_WRD;
				end
			end
			S_FIN: begin
				// hold until the result register can take the final owner
				if (sts.out_free) begin
					cmd.fin_push = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

/* design/hrsw_dp.sv */
// Datapath of the ring lookup: ring memory, search bounds, walk state and result register.
`timescale 1ns / 1ps
module hrsw_dp #(
	parameter int VNODES = hrsw_pkg::VNODES_DEF,
	parameter int NODES  = hrsw_pkg::NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hrsw_pkg::cmd_t                    cmd,
	output hrsw_pkg::sts_t                    sts,
	input  logic [hrsw_pkg::ENTRY_INDEX_W-1:0] entry_index,
	input  logic [hrsw_pkg::ID_W-1:0]          entry_id,
	input  logic [hrsw_pkg::OWNER_W-1:0]       entry_owner,
	input  logic [hrsw_pkg::ID_W-1:0]          key_id,
	input  logic                              cfg_we,
	input  logic [hrsw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hrsw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [hrsw_pkg::OWNER_W-1:0]       out_owner,
	output logic [hrsw_pkg::VNODE_IDX_W-1:0]   out_vnode_index,
	output logic                              out_last
);
	import hrsw_pkg::*;

	localparam int AW      = $clog2(VNODES);
	localparam int CW      = $clog2(VNODES + 1);
	localparam int OWN_CAP = (NODES < OWNER_SLOTS) ? NODES : OWNER_SLOTS;

	// ring memory: owner above id
	logic [OWNER_W+ID_W-1:0] ring_mem [VNODES];
	logic [ID_W-1:0]         rd_id_q;
	logic [OWNER_W-1:0]      rd_own_q;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;

	logic [CW-1:0]      n_q;
	logic [LIMIT_W-1:0] lim_q;
	logic [CW-1:0]      n_sat;
	logic [LIMIT_W-1:0] lim_sat;

	logic [ID_W-1:0] key_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic [CW-1:0]   mid_q;
	logic [CW-1:0]   mid;

	logic [AW-1:0]          pos_q;
	logic [CW-1:0]          pos_inc;
	logic [AW-1:0]          pos_nxt;
	logic [CW-1:0]          steps_q;
	logic [LIMIT_W-1:0]     found_q;
	logic [OWNER_SLOTS-1:0] mask_q;

	logic                   pend_valid_q;
	logic [OWNER_W-1:0]     pend_owner_q;
	logic [AW-1:0]          pend_pos_q;
	logic                   out_valid_q;
	logic                   out_free;

	// clamp register writes to the usable range
	always_comb begin
		if (cfg_data == '0) begin
			n_sat = CW'(1);
		end else if (32'(cfg_data) > VNODES) begin
			n_sat = CW'(VNODES);
		end else begin
			n_sat = CW'(cfg_data);
		end
		if (cfg_data[LIMIT_W-1:0] == '0) begin
			lim_sat = LIMIT_W'(1);
		end else if (32'(cfg_data[LIMIT_W-1:0]) > OWN_CAP) begin
			lim_sat = LIMIT_W'(OWN_CAP);
		end else begin
			lim_sat = cfg_data[LIMIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= CW'(1);
			lim_q <= LIMIT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VNODE_COUNT: n_q   <= n_sat;
				CFG_NODE_COUNT:  lim_q <= lim_sat;
				default: begin
				end
			endcase
		end
	end

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_en   = cmd.srch_rd | cmd.walk_rd;
	assign rd_addr = cmd.srch_rd ? mid[AW-1:0] : pos_q;

	always_ff @(posedge clk) begin
		if (cmd.load && (32'(entry_index) < VNODES)) begin
			ring_mem[AW'(entry_index)] <= {entry_owner, entry_id};
		end
		if (rd_en) begin
			{rd_own_q, rd_id_q} <= ring_mem[rd_addr];
		end
	end

	// lower-bound search bounds
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= key_id;
			lo_q  <= '0;
			hi_q  <= n_q;
		end else if (cmd.srch_upd) begin
			if (rd_id_q < key_q) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.srch_rd) begin
			mid_q <= mid;
		end
	end

	assign pos_inc = CW'(pos_q) + CW'(1);
	assign pos_nxt = (pos_inc >= n_q) ? '0 : pos_inc[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			// wrap to entry 0 when every id is below the key
			pos_q   <= (lo_q >= n_q) ? '0 : lo_q[AW-1:0];
			steps_q <= '0;
			found_q <= '0;
		end else if (cmd.walk_step || cmd.walk_take) begin
			pos_q   <= pos_nxt;
			steps_q <= steps_q + CW'(1);
			if (cmd.walk_take) begin
				found_q      <= found_q + LIMIT_W'(1);
				pend_owner_q <= rd_own_q;
				pend_pos_q   <= pos_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.walk_init) begin
			mask_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.walk_take) begin
			mask_q[rd_own_q] <= 1'b1;
			pend_valid_q     <= 1'b1;
		end else if (cmd.fin_push) begin
			pend_valid_q <= 1'b0;
		end
	end

	// result register: an owner leaves the pending slot once its successor is known
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.walk_take && pend_valid_q) || cmd.fin_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.walk_take && pend_valid_q) || cmd.fin_push) begin
			out_owner       <= pend_owner_q;
			out_vnode_index <= VNODE_IDX_W'(pend_pos_q);
			out_last        <= cmd.fin_push;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.srch_more  = lo_q < hi_q;
	assign sts.walk_more  = (steps_q < n_q) && (found_q < lim_q);
	assign sts.is_new     = !mask_q[rd_own_q];
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

endmodule

/* design/hash_ring_successor_walk.sv */
// Top level of the consistent-hashing ring lookup with successor walk.
// Load request: the ring entry is written at the accept edge.
// Lookup request: a binary search (at most floor(log2(n))+1 probes, each a read then a compare), then a
// walk (a read then an evaluation per entry), all on the single ring memory read port; a held result stalls the walk.
// One request at a time; the next is taken while the final owner still waits for the sink.
// Reset clears the sequencer, result valid flag and both counts (to 1); ring memory is undefined.
`timescale 1ns / 1ps
module hash_ring_successor_walk #(
	parameter int VNODES = hrsw_pkg::VNODES_DEF,
	parameter int NODES  = hrsw_pkg::NODES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// entry_index[9:0], entry_id[73:10], entry_owner[77:74], key_id[141:78], zero[143:142]
	input  logic [hrsw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// func[0]
	input  logic [0:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// owner[3:0], vnode_index[13:4], zero[15:14]
	output logic [hrsw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hrsw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hrsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import hrsw_pkg::*;

	cmd_t                   cmd;
	sts_t                   sts;
	logic [OWNER_W-1:0]     out_owner;
	logic [VNODE_IDX_W-1:0] out_vnode_index;

	assign cfg_ready = 1'b1;

	hrsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_func  (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hrsw_dp #(
		.VNODES (VNODES),
		.NODES  (NODES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.entry_index     (s_axis_tdata[9:0]),
		.entry_id        (s_axis_tdata[73:10]),
		.entry_owner     (s_axis_tdata[77:74]),
		.key_id          (s_axis_tdata[141:78]),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_owner       (out_owner),
		.out_vnode_index (out_vnode_index),
		.out_last        (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, out_vnode_index, out_owner};

endmodule

/* design/hrsw_chk.sv */
// Port-level checker of the ring lookup, bound to the top level.
`timescale 1ns / 1ps
`include "hash_ring_successor_walk_assert.svh"
module hrsw_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [0:0]                     s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [hrsw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);
	import hrsw_pkg::*;

	logic                   lookup_acc;
	logic                   out_acc;
	logic                   last_acc;
	logic [1:0]             open_q;
	logic [OWNER_SLOTS-1:0] seen_q;

	assign lookup_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_LOOKUP);
	assign out_acc    = m_axis_tvalid && m_axis_tready;
	assign last_acc   = out_acc && m_axis_tlast;

	// count lookups whose final owner has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 2'(lookup_acc) - 2'(last_acc);
		end
	end

	// owners already delivered for the current lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (last_acc) begin
			seen_q <= '0;
		end else if (out_acc) begin
			seen_q[m_axis_tdata[3:0]] <= 1'b1;
		end
	end

	`HRSW_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	`HRSW_ASSERT_IMP(a_owner_distinct, clk, arst_n, out_acc, !seen_q[m_axis_tdata[3:0]])
	`HRSW_ASSERT_IMP(a_result_has_lookup, clk, arst_n, m_axis_tvalid, open_q != 2'd0)
	`HRSW_ASSERT_IMP(a_no_third_lookup, clk, arst_n, lookup_acc, open_q != 2'd2)

endmodule

bind hash_ring_successor_walk hrsw_chk u_hrsw_chk (.*);
